FILE: design/kmsr_pkg.sv
package kmsr_pkg;

  localparam int COLUMNS    = 10;
  localparam int ROWS       = 5;
  localparam int ROM_SIZE   = 50;
  localparam int SLOT_COUNT = 6;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 4;
  localparam int KEY_W      = $clog2(COLUMNS * ROWS);
  localparam int COL_IDX_W  = $clog2(COLUMNS);
  localparam int ROM_IDX_W  = $clog2(ROM_SIZE);
  localparam int FILL_W     = $clog2(SLOT_COUNT + 1);

  typedef logic [7:0] code_t;

  localparam code_t SHIFT_CODE = 8'he1;
  localparam code_t SHIFT_BIT  = 8'h02;

  // key code per matrix position, indexed column * ROWS + row
  localparam code_t CODE_ROM [ROM_SIZE] = '{
    8'h00, 8'h1e, 8'h14, 8'h04, 8'he1,
    8'h00, 8'h1f, 8'h1a, 8'h16, 8'h1d,
    8'h00, 8'h20, 8'h08, 8'h07, 8'h1b,
    8'h00, 8'h21, 8'h15, 8'h09, 8'h06,
    8'h2c, 8'h22, 8'h17, 8'h0a, 8'h19,
    8'h50, 8'h23, 8'h1c, 8'h0b, 8'h05,
    8'h4f, 8'h24, 8'h18, 8'h0d, 8'h11,
    8'h00, 8'h25, 8'h0c, 8'h0e, 8'h10,
    8'h28, 8'h26, 8'h12, 8'h0f, 8'h37,
    8'h29, 8'h27, 8'h13, 8'h2a, 8'h00
  };

  function automatic code_t rom_code(input logic [KEY_W-1:0] idx);
    code_t code;
    code = '0;
    if (int'(idx) < ROM_SIZE) begin
      code = CODE_ROM[ROM_IDX_W'(idx)];
    end
    return code;
  endfunction

endpackage

FILE: design/key_matrix_scan_report.sv
// Key matrix scanner producing a keyboard report per column scan.
// Input channel: in_valid / in_stall with in_row_levels, the row levels
// sensed while the current column is driven (0 = pressed). Result channel:
// out_valid / out_stall with send flag, modifier byte, six key code slots
// and the column that the beat belongs to.
// A beat is taken into an input register, then processed combinationally into
// the result register. One beat per cycle is sustained while the receiver does
// not stall; the column scan is a single pass of five parallel compares plus a
// short slot-packing chain.
// Reset (rst_n low, synchronous) clears the stored key levels (all keys
// read as pressed), the modifier byte and the column counter, and empties
// both registers.
// When the receiver stalls, the result register holds its beat; the input
// register still takes one more beat, after which in_stall rises until the
// result beat is taken.
module key_matrix_scan_report (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kmsr_pkg::ROW_W-1:0]    in_row_levels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_send_report,
  output logic [7:0]                    out_modifier_byte,
  output logic [7:0]                    out_slot_zero,
  output logic [7:0]                    out_slot_one,
  output logic [7:0]                    out_slot_two,
  output logic [7:0]                    out_slot_three,
  output logic [7:0]                    out_slot_four,
  output logic [7:0]                    out_slot_five,
  output logic [kmsr_pkg::COL_W-1:0]    out_scanned_column
);

  logic                             s1_valid_r;
  logic [kmsr_pkg::ROW_W-1:0]       s1_rows_r;
  logic                             s1_go;

  logic [kmsr_pkg::ROWS-1:0]        levels_r [kmsr_pkg::COLUMNS];
  logic [kmsr_pkg::ROWS-1:0]        levels_nxt;
  logic [7:0]                       mod_r;
  logic [7:0]                       mod_nxt;
  logic [kmsr_pkg::COL_W-1:0]       col_r;
  logic [kmsr_pkg::COL_W-1:0]       col_nxt;
  logic [kmsr_pkg::COL_W-1:0]       col_cur;
  logic [kmsr_pkg::COL_IDX_W-1:0]   col_idx;
  logic [kmsr_pkg::KEY_W-1:0]       key_base;
  logic [kmsr_pkg::KEY_W-1:0]       key_idx;
  logic [kmsr_pkg::ROWS-1:0]        cur_levels;
  logic                             lvl;
  kmsr_pkg::code_t                  code;
  kmsr_pkg::code_t                  slots [kmsr_pkg::SLOT_COUNT];
  logic [kmsr_pkg::FILL_W-1:0]      fill;
  logic                             changed;

  logic                             out_valid_r;
  logic                             send_r;
  logic [7:0]                       mod_out_r;
  kmsr_pkg::code_t                  slots_r [kmsr_pkg::SLOT_COUNT];
  logic [kmsr_pkg::COL_W-1:0]       col_out_r;

  assign s1_go    = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_go;

  always_comb begin
    col_cur    = (int'(col_r) >= kmsr_pkg::COLUMNS) ? '0 : col_r;
    col_idx    = kmsr_pkg::COL_IDX_W'(col_cur);
    key_base   = kmsr_pkg::KEY_W'(int'(col_cur) * kmsr_pkg::ROWS);
    cur_levels = levels_r[col_idx];
    levels_nxt = cur_levels;
    mod_nxt    = mod_r;
    changed    = 1'b0;
    fill       = '0;
    key_idx    = '0;
    lvl        = 1'b0;
    code       = '0;
    for (int s = 0; s < kmsr_pkg::SLOT_COUNT; s++) begin
      slots[s] = '0;
    end
    for (int r = 0; r < kmsr_pkg::ROWS; r++) begin
      // rows past the input field read as pressed
      lvl     = (r < kmsr_pkg::ROW_W) ? s1_rows_r[r] : 1'b0;
      key_idx = key_base + kmsr_pkg::KEY_W'(r);
      code    = kmsr_pkg::rom_code(key_idx);
      if (cur_levels[r] != lvl) begin
        levels_nxt[r] = lvl;
        changed       = 1'b1;
        if (code == kmsr_pkg::SHIFT_CODE) begin
          mod_nxt = lvl ? (mod_nxt & ~kmsr_pkg::SHIFT_BIT) : (mod_nxt | kmsr_pkg::SHIFT_BIT);
        end
        // a zero code would leave its slot empty, so it takes none
        if (!lvl && code != '0 && int'(fill) < kmsr_pkg::SLOT_COUNT) begin
          slots[fill] = code;
          fill        = fill + 1'b1;
        end
      end
    end
    col_nxt = (int'(col_cur) + 1 >= kmsr_pkg::COLUMNS) ? '0 : col_cur + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mod_r       <= '0;
      col_r       <= '0;
      for (int c = 0; c < kmsr_pkg::COLUMNS; c++) begin
        levels_r[c] <= '0;
      end
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r       <= 1'b1;
        levels_r[col_idx] <= levels_nxt;
        mod_r             <= mod_nxt;
        col_r             <= col_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_rows_r <= in_row_levels;
    end
    if (s1_go) begin
      send_r    <= changed;
      mod_out_r <= mod_nxt;
      col_out_r <= col_cur;
      for (int s = 0; s < kmsr_pkg::SLOT_COUNT; s++) begin
        slots_r[s] <= slots[s];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_send_report    = send_r;
  assign out_modifier_byte  = mod_out_r;
  assign out_slot_zero      = slots_r[0];
  assign out_slot_one       = slots_r[1];
  assign out_slot_two       = slots_r[2];
  assign out_slot_three     = slots_r[3];
  assign out_slot_four      = slots_r[4];
  assign out_slot_five      = slots_r[5];
  assign out_scanned_column = col_out_r;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_COLS       = kmsr_pkg::COLUMNS;
  localparam int NUM_ROWS       = kmsr_pkg::ROWS;
  localparam int NUM_SLOTS      = kmsr_pkg::SLOT_COUNT;
  localparam int NUM_KEYS       = NUM_COLS * NUM_ROWS;
  localparam int CODE_TABLE_LEN = 50;
  localparam int MAX_SHOWN      = 10;

  localparam logic [7:0] LSHIFT_KEY  = 8'he1;
  localparam logic [7:0] LSHIFT_MASK = 8'h02;
  localparam logic [4:0] ALL_UP      = 5'h1f;
  localparam logic [4:0] ALL_DOWN    = 5'h00;

  // usage code per key, column-major: column * rows + row
  localparam logic [7:0] KEY_CODES [CODE_TABLE_LEN] = '{
    8'h00, 8'h1e, 8'h14, 8'h04, 8'he1,
    8'h00, 8'h1f, 8'h1a, 8'h16, 8'h1d,
    8'h00, 8'h20, 8'h08, 8'h07, 8'h1b,
    8'h00, 8'h21, 8'h15, 8'h09, 8'h06,
    8'h2c, 8'h22, 8'h17, 8'h0a, 8'h19,
    8'h50, 8'h23, 8'h1c, 8'h0b, 8'h05,
    8'h4f, 8'h24, 8'h18, 8'h0d, 8'h11,
    8'h00, 8'h25, 8'h0c, 8'h0e, 8'h10,
    8'h28, 8'h26, 8'h12, 8'h0f, 8'h37,
    8'h29, 8'h27, 8'h13, 8'h2a, 8'h00
  };

  typedef struct packed {
    logic                 send;
    logic [7:0]           mods;
    logic [5:0][7:0]      slots;
    logic [3:0]           col;
  } scan_report_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic [kmsr_pkg::ROW_W-1:0]       in_row_levels;
  logic                             out_valid;
  logic                             out_stall;
  logic                             out_send_report;
  logic [7:0]                       out_modifier_byte;
  logic [7:0]                       out_slot_zero;
  logic [7:0]                       out_slot_one;
  logic [7:0]                       out_slot_two;
  logic [7:0]                       out_slot_three;
  logic [7:0]                       out_slot_four;
  logic [7:0]                       out_slot_five;
  logic [kmsr_pkg::COL_W-1:0]       out_scanned_column;

  key_matrix_scan_report u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_row_levels      (in_row_levels),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_send_report    (out_send_report),
    .out_modifier_byte  (out_modifier_byte),
    .out_slot_zero      (out_slot_zero),
    .out_slot_one       (out_slot_one),
    .out_slot_two       (out_slot_two),
    .out_slot_three     (out_slot_three),
    .out_slot_four      (out_slot_four),
    .out_slot_five      (out_slot_five),
    .out_scanned_column (out_scanned_column)
  );

  // predictor state
  logic         key_seen [NUM_KEYS];
  logic [7:0]   mod_state;
  int           col_ptr;

  scan_report_t pending_reports [$];
  int           mismatches;
  int           idle_cycles;
  bit           send_calm;
  bit           recv_calm;
  logic [4:0]   held_rows [NUM_COLS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic scan_report_t scan_column(input logic [4:0] levels);
    scan_report_t rep;
    int           col;
    int           idx;
    logic [7:0]   code;
    bit           placed;
    rep = '0;
    col = (col_ptr >= NUM_COLS) ? 0 : col_ptr;
    for (int r = 0; r < NUM_ROWS; r++) begin
      idx = col * NUM_ROWS + r;
      if (key_seen[idx] != levels[r]) begin
        key_seen[idx] = levels[r];
        rep.send      = 1'b1;
        code          = (idx < CODE_TABLE_LEN) ? KEY_CODES[idx] : 8'h00;
        if (code == LSHIFT_KEY) begin
          mod_state = levels[r] ? (mod_state & ~LSHIFT_MASK) : (mod_state | LSHIFT_MASK);
        end
        // new press: first empty slot gets the code, zero codes leave it empty
        if (!levels[r]) begin
          placed = 1'b0;
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!placed && rep.slots[s] == 8'h00) begin
              rep.slots[s] = code;
              placed       = 1'b1;
            end
          end
        end
      end
    end
    rep.mods = mod_state;
    rep.col  = col[3:0];
    col_ptr  = (col + 1 >= NUM_COLS) ? 0 : col + 1;
    return rep;
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 11));
  endfunction

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("MISMATCH %s: expected 0x%0h, actual 0x%0h", what, want, got);
    end
  endtask

  // one beat on the input channel; valid stays up across back-to-back beats
  task automatic send_scan(input logic [4:0] levels);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_row_levels <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_reports.push_back(scan_column(levels));
  endtask

  task automatic test_power_up_scan();
    // store resets to all pressed: full release, then full press of every column
    for (int c = 0; c < NUM_COLS; c++) send_scan(ALL_UP);
    for (int c = 0; c < NUM_COLS; c++) send_scan(ALL_DOWN);
  endtask

  task automatic test_shift_hold();
    send_scan(5'b01111);  // shift stays down, rest of column 0 released
    send_scan(ALL_DOWN);  // unchanged column, no send
    send_scan(5'b10101);
  endtask

  task automatic test_random_typing(input int n_beats);
    int c;
    for (int c2 = 0; c2 < NUM_COLS; c2++) held_rows[c2] = ALL_UP;
    for (int i = 0; i < n_beats; i++) begin
      c = col_ptr;
      for (int r = 0; r < NUM_ROWS; r++) begin
        if ($urandom_range(0, 9) == 0) held_rows[c][r] = ~held_rows[c][r];
      end
      send_scan(held_rows[c]);
    end
  endtask

  task automatic test_line_noise(input int n_beats);
    for (int i = 0; i < n_beats; i++) send_scan(5'($urandom_range(0, 31)));
  endtask

  // result side: random stall before each beat
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_calm = ~recv_calm;
      gap = draw_wait(recv_calm);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    scan_report_t want;
    scan_report_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.send  = out_send_report;
      got.mods  = out_modifier_byte;
      got.slots = {out_slot_five, out_slot_four, out_slot_three,
                   out_slot_two, out_slot_one, out_slot_zero};
      got.col   = out_scanned_column;
      if (pending_reports.size() == 0) begin
        note_mismatch("beat with nothing expected", 0, 1);
      end else begin
        want = pending_reports.pop_front();
        if (got.send !== want.send) note_mismatch("send_report", want.send, got.send);
        if (got.mods !== want.mods) note_mismatch("modifier_byte", want.mods, got.mods);
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (got.slots[s] !== want.slots[s]) begin
            note_mismatch($sformatf("slot %0d", s), want.slots[s], got.slots[s]);
          end
        end
        if (got.col !== want.col) note_mismatch("scanned_column", want.col, got.col);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_row_levels <= '0;
    out_stall     <= 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    send_calm   = 1'b0;
    recv_calm   = 1'b0;
    mod_state   = 8'h00;
    col_ptr     = 0;
    for (int k = 0; k < NUM_KEYS; k++) key_seen[k] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_up_scan();
    test_shift_hold();
    test_random_typing(1200);
    test_line_noise(400);

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
